// ===== sv/pts_pkg.sv =====
package pts_pkg;

  localparam int DEF_SLOTS     = 16;
  localparam int DEF_TIME_BITS = 48;

  localparam int ID_W    = 8;
  localparam int PER_W   = 24;
  localparam int NOW_W   = 48;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  // A 24-bit period in milliseconds times 1000 fits in 34 bits.
  localparam int STEP_W  = 34;

  localparam logic [9:0] US_PER_MS = 10'd1000;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [ID_W-1:0]  timer_id;
    logic [PER_W-1:0] period_ms;
    logic [NOW_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   fired_id;
    logic [NOW_W-1:0]  deadline_us;
    logic [STAT_W-1:0] status;
    logic              last;
  } res_t;

endpackage

// ===== sv/pts_in_if.sv =====
interface pts_in_if
  import pts_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [ID_W-1:0]  timer_id;
  logic [PER_W-1:0] period_ms;
  logic [NOW_W-1:0] now_us;

  modport source (output valid, opcode, timer_id, period_ms, now_us, input ready);
  modport sink   (input valid, opcode, timer_id, period_ms, now_us, output ready);
endinterface

// ===== sv/pts_out_if.sv =====
interface pts_out_if
  import pts_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ID_W-1:0]   fired_id;
  logic [NOW_W-1:0]  deadline_us;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, kind, fired_id, deadline_us, status, last, input ready);
  modport sink   (input valid, kind, fired_id, deadline_us, status, last, output ready);
endinterface

// ===== sv/pts_ram.sv =====
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pts_alu.sv =====
module pts_alu
  import pts_pkg::*;
#(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic [TIME_BITS-1:0] a,
  input  logic [TIME_BITS-1:0] b,
  input  logic [STEP_W-1:0]    step,
  output logic [TIME_BITS-1:0] sum,
  output logic                 lt
);

  localparam int SUM_W = ((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W) + 1;

  logic [SUM_W-1:0] wide;

  // Time sums saturate at the largest representable time.
  always_comb begin
    wide = SUM_W'(a) + SUM_W'(step);
    if (wide > SUM_W'({TIME_BITS{1'b1}})) begin
      sum = {TIME_BITS{1'b1}};
    end else begin
      sum = TIME_BITS'(wide);
    end
    lt = (a < b);
  end

endmodule

// ===== sv/pts_ctrl.sv =====
module pts_ctrl
  import pts_pkg::*;
#(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  in_item_t                              item,
  output logic                                  res_valid,
  output res_t                                  res,
  input  logic                                  res_ready,
  output logic                                  ram_we,
  output logic [$clog2(SLOTS)-1:0]              ram_waddr,
  output logic [ID_W+PER_W+TIME_BITS-1:0]       ram_wdata,
  output logic [$clog2(SLOTS)-1:0]              ram_raddr,
  input  logic [ID_W+PER_W+TIME_BITS-1:0]       ram_rdata,
  output logic [TIME_BITS-1:0]                  alu_a,
  output logic [TIME_BITS-1:0]                  alu_b,
  output logic [STEP_W-1:0]                     alu_step,
  input  logic [TIME_BITS-1:0]                  alu_sum,
  input  logic                                  alu_lt
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int BUD_W = $clog2(2 * SLOTS + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_L_RD  = 5'd1;
  localparam logic [4:0] S_L_CK  = 5'd2;
  localparam logic [4:0] S_D_RD  = 5'd3;
  localparam logic [4:0] S_D_WR  = 5'd4;
  localparam logic [4:0] S_MUL   = 5'd5;
  localparam logic [4:0] S_ADD   = 5'd6;
  localparam logic [4:0] S_I_RD  = 5'd7;
  localparam logic [4:0] S_I_CK  = 5'd8;
  localparam logic [4:0] S_I_PUT = 5'd9;
  localparam logic [4:0] S_T_RD  = 5'd10;
  localparam logic [4:0] S_T_CK  = 5'd11;
  localparam logic [4:0] S_T_ADD = 5'd12;
  localparam logic [4:0] S_T_CMP = 5'd13;
  localparam logic [4:0] S_T_RE  = 5'd14;
  localparam logic [4:0] S_EMIT  = 5'd15;

  logic [4:0]           state;
  logic [OP_W-1:0]      op;
  logic [ID_W-1:0]      cur_id;
  logic [PER_W-1:0]     cur_per;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] ndl;
  logic [STEP_W-1:0]    step;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     idx;
  logic [BUD_W-1:0]     budget;

  logic [ID_W-1:0]      rd_id;
  logic [PER_W-1:0]     rd_per;
  logic [TIME_BITS-1:0] rd_dl;

  function automatic res_t mk_res(logic k, logic [ID_W-1:0] id, logic [NOW_W-1:0] dl,
                                  logic [STAT_W-1:0] st, logic lst);
    res_t r;
    r.kind        = k;
    r.fired_id    = id;
    r.deadline_us = dl;
    r.status      = st;
    r.last        = lst;
    return r;
  endfunction

  assign rd_id  = ram_rdata[ID_W+PER_W+TIME_BITS-1 -: ID_W];
  assign rd_per = ram_rdata[PER_W+TIME_BITS-1 -: PER_W];
  assign rd_dl  = ram_rdata[TIME_BITS-1:0];

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign alu_step  = step;

  always_comb begin
    alu_a = ndl;
    alu_b = now;
    unique case (state)
      S_ADD, S_T_RE: alu_a = now;
      S_T_CK: begin
        alu_a = now;
        alu_b = rd_dl;
      end
      S_I_CK:  alu_b = rd_dl;
      default: alu_a = ndl;
    endcase
  end

  always_comb begin
    ram_raddr = IDX_W'(idx);
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(idx);
    ram_wdata = ram_rdata;
    unique case (state)
      S_D_RD:  ram_raddr = IDX_W'(idx + CNT_W'(1));
      S_I_RD:  ram_raddr = IDX_W'(idx - CNT_W'(1));
      S_T_RD:  ram_raddr = '0;
      S_D_WR:  ram_we = 1'b1;
      S_I_CK:  ram_we = alu_lt;
      S_I_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = {cur_id, cur_per, ndl};
      end
      default: ram_raddr = IDX_W'(idx);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= item.opcode;
            cur_id  <= item.timer_id;
            cur_per <= (item.period_ms == '0) ? PER_W'(1) : item.period_ms;
            now     <= TIME_BITS'(item.now_us);
            idx     <= '0;
            budget  <= BUD_W'(2 * SLOTS);
            state   <= (item.opcode == OP_TICK) ? S_T_RD : S_L_RD;
          end
        end
        S_L_RD: begin
          if (idx == cnt) begin
            if (op == OP_START) begin
              if (cnt == CNT_W'(SLOTS)) begin
                res   <= mk_res(KIND_DONE, cur_id, '0, ST_FULL, 1'b1);
                state <= S_EMIT;
              end else begin
                state <= S_MUL;
              end
            end else begin
              res   <= mk_res(KIND_DONE, cur_id, '0, ST_NOT_FOUND, 1'b1);
              state <= S_EMIT;
            end
          end else begin
            state <= S_L_CK;
          end
        end
        S_L_CK: begin
          if (rd_id == cur_id) begin
            if (op == OP_QUERY) begin
              res   <= mk_res(KIND_DONE, cur_id, NOW_W'(rd_dl), ST_OK, 1'b1);
              state <= S_EMIT;
            end else begin
              state <= S_D_RD;
            end
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_L_RD;
          end
        end
        // Removal closes the gap by moving each later entry up by one.
        S_D_RD: begin
          if ((idx + CNT_W'(1)) < cnt) begin
            state <= S_D_WR;
          end else begin
            cnt <= cnt - CNT_W'(1);
            if (op == OP_STOP) begin
              res   <= mk_res(KIND_DONE, cur_id, '0, ST_OK, 1'b1);
              state <= S_EMIT;
            end else if (op == OP_TICK) begin
              idx   <= cnt - CNT_W'(1);
              state <= S_I_RD;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_D_WR: begin
          idx   <= idx + CNT_W'(1);
          state <= S_D_RD;
        end
        S_MUL: begin
          step  <= STEP_W'(cur_per) * STEP_W'(US_PER_MS);
          state <= (op == OP_TICK) ? S_T_ADD : S_ADD;
        end
        S_ADD: begin
          ndl   <= alu_sum;
          idx   <= cnt;
          state <= S_I_RD;
        end
        // Insertion walks down from the top, moving later deadlines one slot
        // back, so that the new entry lands after all equal deadlines.
        S_I_RD: begin
          state <= (idx == '0) ? S_I_PUT : S_I_CK;
        end
        S_I_CK: begin
          if (alu_lt) begin
            idx   <= idx - CNT_W'(1);
            state <= S_I_RD;
          end else begin
            state <= S_I_PUT;
          end
        end
        S_I_PUT: begin
          cnt <= cnt + CNT_W'(1);
          if (op == OP_TICK) begin
            res    <= mk_res(KIND_FIRE, cur_id, NOW_W'(ndl), ST_OK, 1'b0);
            budget <= budget - BUD_W'(1);
          end else begin
            res <= mk_res(KIND_DONE, cur_id, '0, ST_OK, 1'b1);
          end
          state <= S_EMIT;
        end
        S_T_RD: begin
          if (cnt == '0 || budget == '0) begin
            res   <= mk_res(KIND_DONE, '0, '0, ST_OK, 1'b1);
            state <= S_EMIT;
          end else begin
            state <= S_T_CK;
          end
        end
        S_T_CK: begin
          if (alu_lt) begin
            res   <= mk_res(KIND_DONE, '0, '0, ST_OK, 1'b1);
            state <= S_EMIT;
          end else begin
            cur_id  <= rd_id;
            cur_per <= rd_per;
            ndl     <= rd_dl;
            state   <= S_MUL;
          end
        end
        S_T_ADD: begin
          ndl   <= alu_sum;
          state <= S_T_CMP;
        end
        // A timer that fell behind is rescheduled from the current time.
        S_T_CMP: begin
          if (alu_lt) begin
            state <= S_T_RE;
          end else begin
            idx   <= '0;
            state <= S_D_RD;
          end
        end
        S_T_RE: begin
          ndl   <= alu_sum;
          idx   <= '0;
          state <= S_D_RD;
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= res.last ? S_IDLE : S_T_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/periodic_timer_scheduler.sv =====
// Sorted periodic timer queue of SLOTS entries, kept earliest deadline first in
// a single-port-write, registered-read table RAM. One shared saturating adder
// and comparator does all time arithmetic under a small sequencer, so one item
// is in work at a time and req.ready is low from acceptance until its final
// result has been handed to the output register. A stop, query or start scans
// the table entry by entry for its timer; a start or stop that finds it then
// moves the later entries up, and a start inserts its timer by moving later
// deadlines back. A tick inspects the head entry and ends if nothing is due.
// Each fired timer is handled by head inspection and arithmetic, removal from
// the head, and reinsertion. One tick fires at most 2*SLOTS times. Every
// result passes through one output register, so a new item is taken while the
// last result waits. Table contents need no clearing after reset; of the table
// state only the entry count is reset.
module periodic_timer_scheduler
  import pts_pkg::*;
#(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input logic       clk,
  input logic       rst,
  pts_in_if.sink    req,
  pts_out_if.source rsp
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int ENT_W = ID_W + PER_W + TIME_BITS;

  in_item_t             item;
  res_t                 res;
  res_t                 res_q;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_valid;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;

  logic [TIME_BITS-1:0] alu_a;
  logic [TIME_BITS-1:0] alu_b;
  logic [TIME_BITS-1:0] alu_sum;
  logic [STEP_W-1:0]    alu_step;
  logic                 alu_lt;

  assign item.opcode    = req.opcode;
  assign item.timer_id  = req.timer_id;
  assign item.period_ms = req.period_ms;
  assign item.now_us    = req.now_us;

  pts_ctrl #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .item      (item),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_step  (alu_step),
    .alu_sum   (alu_sum),
    .alu_lt    (alu_lt)
  );

  pts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pts_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .step (alu_step),
    .sum  (alu_sum),
    .lt   (alu_lt)
  );

  // The output register takes a new result whenever it is empty or its
  // current one is transferred in the same cycle.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = res_q.kind;
  assign rsp.fired_id    = res_q.fired_id;
  assign rsp.deadline_us = res_q.deadline_us;
  assign rsp.status      = res_q.status;
  assign rsp.last        = res_q.last;

endmodule

// ===== sv/pts_checker.sv =====
module pts_checker
  import pts_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              kind,
  input logic [ID_W-1:0]   fired_id,
  input logic [NOW_W-1:0]  deadline_us,
  input logic [STAT_W-1:0] status,
  input logic              last
);

  // A stalled result holds until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(fired_id)
      && $stable(deadline_us) && $stable(status) && $stable(last))
    else $error("stalled result changed");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an input transfer");

  a_fire_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_FIRE |-> status == ST_OK && !last)
    else $error("fire result with status or last set");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DONE |-> last)
    else $error("completion result without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> deadline_us == '0 && kind == KIND_DONE)
    else $error("error completion with nonzero deadline");

endmodule

bind periodic_timer_scheduler pts_checker u_pts_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .kind        (rsp.kind),
  .fired_id    (rsp.fired_id),
  .deadline_us (rsp.deadline_us),
  .status      (rsp.status),
  .last        (rsp.last)
);
